// ----- sv/assert_macros.svh -----
// Assertion macros shared by the online mean and variance block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds on every clock edge out of reset.
`define OMV_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("omv assertion failed");

// Check that a trigger is followed by a condition on the next edge.
`define OMV_ASSERT_NEXT(lbl, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error("omv assertion failed");

`endif

// ----- sv/omv_pkg.sv -----
// Shared constants and command/status types of the online mean and variance block.
package omv_pkg;

  localparam int DEPTH     = 1024;
  localparam int AW        = $clog2(DEPTH);
  localparam int LEN_W     = 11;
  localparam int FRAC      = 16;
  localparam int DW        = 32;
  localparam int SUM_W     = 64;
  localparam int OUT_SUM_W = 63;
  localparam int CNT_W     = 32;
  localparam int DIV_W     = DW + 1;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);
  localparam int PROD_W    = 2 * DIV_W;
  localparam int CFG_IDX_W = 1;

  localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_VARIANCE = 1'b1;

  typedef struct packed {
    logic accept;
    logic div_start;
    logic div_step;
    logic prep;
    logic mul_lo;
    logic mul_hi;
    logic write;
    logic clear;
  } omv_cmd_t;

  typedef struct packed {
    logic div_done;
    logic clr_last;
  } omv_sts_t;

endpackage

// ----- sv/omv_datapath.sv -----
// Datapath: element stores, counters, divider, split multiplier and result register.
module omv_datapath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  omv_pkg::omv_cmd_t              cmd,
  output omv_pkg::omv_sts_t              sts,
  input  logic signed [omv_pkg::DW-1:0]  in_sample_value,
  input  logic                           cfg_we,
  input  logic [omv_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [omv_pkg::LEN_W-1:0]      cfg_data,
  output logic [omv_pkg::AW-1:0]         out_element_index,
  output logic signed [omv_pkg::DW-1:0]  out_running_mean,
  output logic [omv_pkg::OUT_SUM_W-1:0]  out_squared_deviation_sum,
  output logic [omv_pkg::CNT_W-1:0]      out_samples_seen,
  output logic                           out_vector_end
);

  // Element stores
  logic [omv_pkg::DW-1:0]    mean_mem [omv_pkg::DEPTH];
  logic [omv_pkg::SUM_W-1:0] sum_mem  [omv_pkg::DEPTH];

  logic [omv_pkg::LEN_W-1:0] len_r;
  logic                      var_en_r;
  logic [omv_pkg::AW-1:0]    pos_r, idx_r, clr_addr_r;
  logic [omv_pkg::CNT_W-1:0] cnt_r, cnt_nxt, n_r;
  logic                      last_r;
  logic [omv_pkg::DW-1:0]    x_r, mean_rd_r, new_mean_r;
  logic [omv_pkg::SUM_W-1:0] sum_rd_r;
  logic [omv_pkg::DIV_W-1:0] dmag_r, quo_r, d2mag_r;
  logic                      dneg_r, neg_term_r;
  logic [omv_pkg::DW-1:0]    rem_r;
  logic [omv_pkg::DIV_CNT_W-1:0] div_cnt_r;
  logic [omv_pkg::PROD_W-1:0] prod_r;

  logic [omv_pkg::LEN_W-1:0] eff_len;
  logic [omv_pkg::LEN_W-1:0] pos_ext;
  logic [omv_pkg::AW-1:0]    idx_c;
  logic                      last_c;
  logic [omv_pkg::DIV_W-1:0] diff_c, dmag_c;
  logic [omv_pkg::DIV_W-1:0] shifted, qs, nm33, d2_c, d2mag_c;
  logic                      ge;
  logic [omv_pkg::DIV_W+omv_pkg::FRAC-1:0]                 prod_lo_c;
  logic [omv_pkg::DIV_W+(omv_pkg::DIV_W-omv_pkg::FRAC)-1:0] prod_hi_c;
  logic [omv_pkg::SUM_W-1:0] term, sum_add, sum_new;
  logic [omv_pkg::AW-1:0]    wr_addr;

  // Clamp the configured length into one to the store depth
  always_comb begin
    eff_len = len_r;
    if (len_r == '0) eff_len = omv_pkg::LEN_W'(1);
    if (len_r > omv_pkg::LEN_W'(omv_pkg::DEPTH)) eff_len = omv_pkg::LEN_W'(omv_pkg::DEPTH);
    pos_ext = omv_pkg::LEN_W'(pos_r);
    idx_c   = (pos_ext >= eff_len) ? omv_pkg::AW'(eff_len - 1'b1) : pos_r;
    last_c  = (omv_pkg::LEN_W'(idx_c) + 1'b1) >= eff_len;
    cnt_nxt = cnt_r;
    if (idx_c == '0 && cnt_r != omv_pkg::CNT_MAX) cnt_nxt = cnt_r + 1'b1;
  end

  // Difference and its magnitude
  always_comb begin
    diff_c = {x_r[omv_pkg::DW-1], x_r} - {mean_rd_r[omv_pkg::DW-1], mean_rd_r};
    dmag_c = diff_c[omv_pkg::DIV_W-1] ? (~diff_c + 1'b1) : diff_c;
  end

  // One restoring division step
  always_comb begin
    shifted = {rem_r, quo_r[omv_pkg::DIV_W-1]};
    ge      = shifted >= {1'b0, n_r};
  end

  // Signed quotient, new mean and second deviation
  always_comb begin
    qs      = dneg_r ? (~quo_r + 1'b1) : quo_r;
    nm33    = {mean_rd_r[omv_pkg::DW-1], mean_rd_r} + qs;
    d2_c    = {x_r[omv_pkg::DW-1], x_r} - nm33;
    d2mag_c = d2_c[omv_pkg::DIV_W-1] ? (~d2_c + 1'b1) : d2_c;
  end

  // Partial products of the two multiply beats
  always_comb begin
    prod_lo_c = dmag_r * d2mag_r[omv_pkg::FRAC-1:0];
    prod_hi_c = dmag_r * d2mag_r[omv_pkg::DIV_W-1:omv_pkg::FRAC];
  end

  // Saturating accumulation of the scaled product
  always_comb begin
    term    = neg_term_r ? '0 : omv_pkg::SUM_W'(prod_r[omv_pkg::PROD_W-1:omv_pkg::FRAC]);
    sum_add = sum_rd_r + term;
    sum_new = sum_rd_r;
    if (var_en_r) sum_new = (sum_add > omv_pkg::SUM_MAX) ? omv_pkg::SUM_MAX : sum_add;
    wr_addr = cmd.clear ? clr_addr_r : idx_r;
  end

  assign sts.div_done = (div_cnt_r == '0);
  assign sts.clr_last = (clr_addr_r == omv_pkg::AW'(omv_pkg::DEPTH - 1));

  // Control registers: configuration, counters, clearing address
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r      <= omv_pkg::LEN_W'(omv_pkg::DEPTH);
      var_en_r   <= 1'b1;
      pos_r      <= '0;
      cnt_r      <= '0;
      clr_addr_r <= '0;
      div_cnt_r  <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          omv_pkg::CFG_LENGTH:   len_r    <= cfg_data;
          omv_pkg::CFG_VARIANCE: var_en_r <= cfg_data[0];
          default: ;
        endcase
      end
      if (cmd.clear) clr_addr_r <= clr_addr_r + 1'b1;
      if (cmd.accept) begin
        cnt_r <= cnt_nxt;
        pos_r <= last_c ? '0 : idx_c + 1'b1;
      end
      if (cmd.div_start) div_cnt_r <= omv_pkg::DIV_CNT_W'(omv_pkg::DIV_W);
      else if (cmd.div_step) div_cnt_r <= div_cnt_r - 1'b1;
    end
  end

  // Payload registers: capture beat, read stores, divide, multiply
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      x_r       <= in_sample_value;
      idx_r     <= idx_c;
      last_r    <= last_c;
      n_r       <= (cnt_nxt == '0) ? omv_pkg::CNT_W'(1) : cnt_nxt;
      mean_rd_r <= mean_mem[idx_c];
      sum_rd_r  <= sum_mem[idx_c];
    end
    if (cmd.div_start) begin
      dmag_r <= dmag_c;
      dneg_r <= diff_c[omv_pkg::DIV_W-1];
      quo_r  <= dmag_c;
      rem_r  <= '0;
    end else if (cmd.div_step) begin
      rem_r <= ge ? omv_pkg::DW'(shifted - {1'b0, n_r}) : shifted[omv_pkg::DW-1:0];
      quo_r <= {quo_r[omv_pkg::DIV_W-2:0], ge};
    end
    if (cmd.prep) begin
      new_mean_r <= nm33[omv_pkg::DW-1:0];
      d2mag_r    <= d2mag_c;
      neg_term_r <= (dneg_r != d2_c[omv_pkg::DIV_W-1]) && (dmag_r != '0) && (d2_c != '0);
    end
    if (cmd.mul_lo) begin
      prod_r <= omv_pkg::PROD_W'(prod_lo_c);
    end else if (cmd.mul_hi) begin
      prod_r <= prod_r + (omv_pkg::PROD_W'(prod_hi_c) << omv_pkg::FRAC);
    end
    if (cmd.write) begin
      out_element_index         <= idx_r;
      out_running_mean          <= new_mean_r;
      out_squared_deviation_sum <= sum_new[omv_pkg::OUT_SUM_W-1:0];
      out_samples_seen          <= cnt_r;
      out_vector_end            <= last_r;
    end
  end

  // Store write port: clearing sweep or result write-back
  always_ff @(posedge clk) begin
    if (cmd.clear || cmd.write) begin
      mean_mem[wr_addr] <= cmd.clear ? '0 : new_mean_r;
      sum_mem[wr_addr]  <= cmd.clear ? '0 : sum_new;
    end
  end

endmodule

// ----- sv/omv_ctrl.sv -----
// Controller: sequences clearing, division, multiplication and write-back.
`include "assert_macros.svh"
module omv_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output omv_pkg::omv_cmd_t   cmd,
  input  omv_pkg::omv_sts_t   sts
);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_READ, S_DIV, S_PREP, S_MUL0, S_MUL1, S_WRITE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_busy;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_busy  = out_valid_r && out_stall;

  // Decode commands and next state
  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_READ;
        end
      end
      S_READ: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        if (sts.div_done) state_nxt = S_PREP;
        else cmd.div_step = 1'b1;
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = S_MUL0;
      end
      S_MUL0: begin
        cmd.mul_lo = 1'b1;
        state_nxt  = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul_hi = 1'b1;
        state_nxt  = S_WRITE;
      end
      S_WRITE: begin
        if (!out_busy) begin
          cmd.write     = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold state and the result valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `OMV_ASSERT(a_write_free, !cmd.write || !(out_valid_r && out_stall))
  `OMV_ASSERT_NEXT(a_accept_read, in_valid && !in_stall, state_r == S_READ)
  `OMV_ASSERT(a_valid_rise, !$rose(out_valid_r) || $past(cmd.write))

endmodule

// ----- sv/online_mean_variance_vector_top.sv -----
// Top level of the per-element online mean and variance block.
//
//  channel | ports                                  | handshake
//  input   | in_sample_value                        | in_valid / in_stall
//  result  | out_element_index .. out_vector_end    | out_valid / out_stall
//  config  | cfg_index, cfg_data                    | cfg_we
//
// Each element passes through these steps from one accepted beat to the next: take
// the beat, start the 33-step radix-2 divider that forms (x - mean) / n, run
// the divider, then prepare, two multiply beats and write-back.
// After reset all 1024 entries of the stores are swept to zero; no beat is taken then.
// A new beat is taken while the previous result waits in the output register;
// write-back waits only if that register is still full and stalled.
module online_mean_variance_vector_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [omv_pkg::DW-1:0]  in_sample_value,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [omv_pkg::AW-1:0]         out_element_index,
  output logic signed [omv_pkg::DW-1:0]  out_running_mean,
  output logic [omv_pkg::OUT_SUM_W-1:0]  out_squared_deviation_sum,
  output logic [omv_pkg::CNT_W-1:0]      out_samples_seen,
  output logic                           out_vector_end,
  input  logic                           cfg_we,
  input  logic [omv_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [omv_pkg::LEN_W-1:0]      cfg_data
);

  omv_pkg::omv_cmd_t cmd;
  omv_pkg::omv_sts_t sts;

  omv_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  omv_datapath u_dp (
    .clk                       (clk),
    .rst_n                     (rst_n),
    .cmd                       (cmd),
    .sts                       (sts),
    .in_sample_value           (in_sample_value),
    .cfg_we                    (cfg_we),
    .cfg_index                 (cfg_index),
    .cfg_data                  (cfg_data),
    .out_element_index         (out_element_index),
    .out_running_mean          (out_running_mean),
    .out_squared_deviation_sum (out_squared_deviation_sum),
    .out_samples_seen          (out_samples_seen),
    .out_vector_end            (out_vector_end)
  );

endmodule

// ----- tb/sv/tb.sv -----
// Self-checking testbench for the per-element online mean and variance block.
`timescale 1ns / 100ps

module tb;
  import omv_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 60;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic [AW-1:0]        index;
    logic signed [DW-1:0] mean;
    logic [OUT_SUM_W-1:0] dev_sum;
    logic [CNT_W-1:0]     count;
    logic                 last;
  } stat_beat_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_stall;
  logic signed [DW-1:0]   in_sample_value;
  logic                   out_valid;
  logic                   out_stall;
  logic [AW-1:0]          out_element_index;
  logic signed [DW-1:0]   out_running_mean;
  logic [OUT_SUM_W-1:0]   out_squared_deviation_sum;
  logic [CNT_W-1:0]       out_samples_seen;
  logic                   out_vector_end;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [LEN_W-1:0]       cfg_data;

  // Predictor state
  logic signed [DW-1:0]   mean_mem [DEPTH];
  logic [SUM_W-1:0]       dev_mem [DEPTH];
  logic [CNT_W-1:0]       vec_count;
  int unsigned            next_pos;
  logic [LEN_W-1:0]       len_reg;
  logic                   var_en;

  stat_beat_t             pending_stats[$];
  int                     errors;
  int                     cycles;
  int                     send_idle_pct;
  int                     stall_pct;
  int                     hold_left;
  bit                     hold_req;

  online_mean_variance_vector_top u_dut (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Abort on a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic longint unsigned mag(input longint v);
    return v < 0 ? longint'(-v) : v;
  endfunction

  // Apply one element to the predictor and return the result it should give
  function automatic stat_beat_t welford_update(input logic signed [DW-1:0] x);
    stat_beat_t r;
    int unsigned eff, idx;
    bit last, neg;
    longint n, diff, nm, d2;
    longint unsigned term, sum;
    eff = (len_reg == 0) ? 1 : ((len_reg > DEPTH) ? DEPTH : len_reg);
    idx = (next_pos >= eff) ? eff - 1 : next_pos;
    last = (idx + 1 >= eff);
    if (idx == 0 && vec_count != CNT_MAX) vec_count++;
    n = (vec_count == 0) ? 1 : longint'(vec_count);
    diff = longint'(x) - longint'(mean_mem[idx]);
    nm = longint'(mean_mem[idx]) + diff / n;
    mean_mem[idx] = nm[DW-1:0];
    sum = dev_mem[idx];
    if (var_en) begin
      d2 = longint'(x) - nm;
      neg = ((diff < 0) != (d2 < 0)) && diff != 0 && d2 != 0;
      term = neg ? 0 : (mag(diff) * mag(d2)) >> FRAC;
      sum = (term > SUM_MAX - sum) ? SUM_MAX : sum + term;
      dev_mem[idx] = sum;
    end
    next_pos = last ? 0 : idx + 1;
    r.index = idx[AW-1:0];
    r.mean = nm[DW-1:0];
    r.dev_sum = sum[OUT_SUM_W-1:0];
    r.count = vec_count;
    r.last = last;
    return r;
  endfunction

  // Offer one beat, idling first at random; predict on acceptance
  task automatic send_sample(input logic signed [DW-1:0] x);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      in_sample_value <= $urandom;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_sample_value <= x;
    do @(posedge clk); while (in_stall);
    pending_stats.push_back(welford_update(x));
  endtask

  task automatic go_quiet();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Wait for every result, then for the block to go idle
  task automatic settle();
    go_quiet();
    while (pending_stats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LEN_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_LENGTH) len_reg = val;
    else var_en = val[0];
  endtask

  function automatic logic signed [DW-1:0] rand_sample();
    case ($urandom_range(3))
      0: return $signed($urandom_range(131072)) - 65536;
      1: return $urandom_range(1) ? 32'sh7fffffff - $urandom_range(255)
                                  : 32'sh80000000 + $urandom_range(255);
      default: return $urandom;
    endcase
  endfunction

  // Drive the result stall, with an occasional long hold-off
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Check each result beat against the oldest prediction
  always @(posedge clk) begin
    stat_beat_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_element_index, out_running_mean, out_squared_deviation_sum,
              out_samples_seen, out_vector_end};
      if (pending_stats.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat idx=%0d mean=%h", $time, got.index, got.mean);
      end else begin
        want = pending_stats.pop_front();
        if (got.index !== want.index)
          $display("%0t: index exp %0d got %0d", $time, want.index, got.index);
        if (got.mean !== want.mean)
          $display("%0t: mean exp %h got %h", $time, want.mean, got.mean);
        if (got.dev_sum !== want.dev_sum)
          $display("%0t: dev sum exp %h got %h", $time, want.dev_sum, got.dev_sum);
        if (got.count !== want.count)
          $display("%0t: count exp %0d got %0d", $time, want.count, got.count);
        if (got.last !== want.last)
          $display("%0t: vector end exp %b got %b", $time, want.last, got.last);
        if (got !== want) errors++;
      end
    end
  end

  // Field extremes, mean-only mode and the odd vector lengths
  task automatic test_directed();
    write_reg(CFG_LENGTH, 4);
    write_reg(CFG_VARIANCE, 1);
    send_sample(32'sh7fffffff);
    send_sample(32'sh80000000);
    send_sample(0);
    send_sample(-1);
    send_sample(32'sh80000000);
    send_sample(32'sh7fffffff);
    send_sample(-1);
    send_sample(0);
    settle();
    write_reg(CFG_VARIANCE, 0);
    repeat (4) send_sample(rand_sample());
    settle();
    write_reg(CFG_VARIANCE, 1);
    write_reg(CFG_LENGTH, 0);
    repeat (2) send_sample(rand_sample());
    settle();
    write_reg(CFG_LENGTH, 11'd2047);
    repeat (3) send_sample(rand_sample());
    settle();
    // Shorten the length, then lower it below the current position
    write_reg(CFG_LENGTH, 8);
    repeat (4) send_sample(rand_sample());
    settle();
    write_reg(CFG_LENGTH, 3);
    repeat (3) send_sample(rand_sample());
    settle();
  endtask

  task automatic test_random_phase(input int idle, input int stall, input int items);
    send_idle_pct = idle;
    stall_pct = stall;
    write_reg(CFG_VARIANCE, LEN_W'($urandom_range(1)));
    case ($urandom_range(9))
      0: write_reg(CFG_LENGTH, LEN_W'(DEPTH));
      1: write_reg(CFG_LENGTH, 0);
      default: write_reg(CFG_LENGTH, LEN_W'($urandom_range(1, 16)));
    endcase
    repeat (items) send_sample(rand_sample());
    settle();
  endtask

  // Hold the result side off while the sender keeps offering beats
  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct = 0;
    write_reg(CFG_LENGTH, 5);
    @(posedge clk);
    hold_req = 1'b1;
    repeat (20) send_sample(rand_sample());
    settle();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_sample_value = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_LENGTH;
    cfg_data = '0;
    errors = 0;
    cycles = 0;
    hold_left = 0;
    hold_req = 1'b0;
    send_idle_pct = 0;
    stall_pct = 0;
    vec_count = '0;
    next_pos = 0;
    len_reg = DEPTH;
    var_en = 1'b1;
    foreach (mean_mem[i]) begin
      mean_mem[i] = '0;
      dev_mem[i] = '0;
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_random_phase(0, 0, 30);
    test_random_phase(72, 0, 60);
    test_random_phase(0, 72, 60);
    test_random_phase(15, 15, 60);
    test_random_phase(0, 0, 60);
    test_random_phase(72, 72, 40);
    test_random_phase(15, 15, 60);
    test_backpressure();
    write_reg(CFG_LENGTH, 11'd1024);
    repeat (10) send_sample(rand_sample());
    settle();
    write_reg(CFG_LENGTH, 11'd2);
    repeat (4) send_sample(rand_sample());
    settle();

    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
